// File: src/bbw_pkg.sv
// ----------------------------------------------------------------------------
// bbw_pkg
// Widths, register codes and shared types for the bollinger band window.
// ----------------------------------------------------------------------------
package bbw_pkg;

  // ring depth, sets the widths of everything that scales with the window
  localparam int unsigned MAX_WINDOW = 64;

  localparam int unsigned PRICE_W = 24;
  localparam int unsigned WL_W    = 7;
  localparam int unsigned BW_W    = 12;
  localparam int unsigned BAND_W  = 28;
  localparam int unsigned BW_FRAC = 8;

  localparam int unsigned SLOT_W = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W  = PRICE_W + SLOT_W;
  localparam int unsigned SQ_W   = 2 * PRICE_W + SLOT_W;
  localparam int unsigned NUM_W  = 2 * PRICE_W + 2 * SLOT_W;

  // variance stays below 2^(2*PRICE_W-2), so its quotient has this many bits
  localparam int unsigned VAR_Q = 2 * PRICE_W - 2;
  localparam int unsigned DSQ_W = 2 * LEN_W;
  localparam int unsigned REM_W = DSQ_W + 1;
  localparam int unsigned CNT_W = $clog2(VAR_Q + 1);

  localparam int unsigned MUL_W = SUM_W;
  localparam int unsigned ADD_W = NUM_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = BW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_WIDTH    = CFG_IDX_W'(1);

  localparam logic [WL_W-1:0] WL_RESET = WL_W'(20);
  localparam logic [BW_W-1:0] BW_RESET = BW_W'(512);

  typedef struct packed {
    logic sub;
    logic mul_en;
  } alu_ctrl_t;

endpackage

// File: src/bollinger_band_window.sv
// ----------------------------------------------------------------------------
// bollinger_band_window
// Middle, upper and lower bollinger bands over a sliding window of prices.
// ----------------------------------------------------------------------------
// One price beat is taken at a time and the block is not ready until its
// result has moved to the output register. While the window is still filling
// a beat runs only the window update and then moves to the output. With a
// full window the window update, the mean and the variance run on one
// shared adder and one shared multiplier, and the time is set by the
// restoring divides (24 steps for the mean, 46 for the variance) and the
// 23-step square root, one step per cycle on the shared subtractor. A result
// waiting at the output does not hold off the next price beat. The price ring
// has no clearing pass; a write to window_length restarts the window at once.
module bollinger_band_window (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bbw_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [bbw_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bbw_pkg::PRICE_W-1:0]           close_price_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  bands_valid_o,
  output logic [bbw_pkg::PRICE_W-1:0]           middle_band_o,
  output logic [bbw_pkg::BAND_W-1:0]            upper_band_o,
  output logic signed [bbw_pkg::BAND_W-1:0]     lower_band_o
);

  localparam int unsigned PRICE_W = bbw_pkg::PRICE_W;
  localparam int unsigned SLOT_W  = bbw_pkg::SLOT_W;
  localparam int unsigned LEN_W   = bbw_pkg::LEN_W;
  localparam int unsigned SUM_W   = bbw_pkg::SUM_W;
  localparam int unsigned SQ_W    = bbw_pkg::SQ_W;
  localparam int unsigned NUM_W   = bbw_pkg::NUM_W;
  localparam int unsigned VAR_Q   = bbw_pkg::VAR_Q;
  localparam int unsigned DSQ_W   = bbw_pkg::DSQ_W;
  localparam int unsigned REM_W   = bbw_pkg::REM_W;
  localparam int unsigned CNT_W   = bbw_pkg::CNT_W;
  localparam int unsigned MUL_W   = bbw_pkg::MUL_W;
  localparam int unsigned ADD_W   = bbw_pkg::ADD_W;
  localparam int unsigned BAND_W  = bbw_pkg::BAND_W;

  localparam logic [LEN_W:0]   MaxWin   = (LEN_W + 1)'(bbw_pkg::MAX_WINDOW);
  localparam logic [VAR_Q-1:0] RootBit0 = VAR_Q'(1) << (VAR_Q - 2);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOAD  = 5'd1;
  localparam logic [4:0] S_UPD1  = 5'd2;
  localparam logic [4:0] S_UPD2  = 5'd3;
  localparam logic [4:0] S_UPD3  = 5'd4;
  localparam logic [4:0] S_SQS   = 5'd5;
  localparam logic [4:0] S_NLO   = 5'd6;
  localparam logic [4:0] S_NHI   = 5'd7;
  localparam logic [4:0] S_NCOMB = 5'd8;
  localparam logic [4:0] S_NUM   = 5'd9;
  localparam logic [4:0] S_DIVM  = 5'd10;
  localparam logic [4:0] S_VSET  = 5'd11;
  localparam logic [4:0] S_DIVV  = 5'd12;
  localparam logic [4:0] S_RSET  = 5'd13;
  localparam logic [4:0] S_SQRT  = 5'd14;
  localparam logic [4:0] S_SCALE = 5'd15;
  localparam logic [4:0] S_UP    = 5'd16;
  localparam logic [4:0] S_LO    = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  logic [4:0] state_q, state_d;

  logic [bbw_pkg::WL_W-1:0] wl_q;
  logic [bbw_pkg::BW_W-1:0] bw_q;
  logic [SLOT_W-1:0]        slot_q;
  logic [LEN_W-1:0]         fill_q;
  logic [SUM_W-1:0]         sum_q;
  logic [SQ_W-1:0]          sq_q;
  logic                     out_valid_q;

  logic [PRICE_W-1:0]   price_q;
  logic                 full_q;
  logic                 vld_q;
  logic [2*PRICE_W-1:0] nsq_q;
  logic [NUM_W-1:0]     acc_q;
  logic [NUM_W-1:0]     t_q;
  logic [REM_W-1:0]     rem_q;
  logic [VAR_Q-1:0]     dvd_q;
  logic [VAR_Q-1:0]     quo_q;
  logic [DSQ_W-1:0]     div_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [VAR_Q-1:0]     root_q;
  logic [VAR_Q-1:0]     bit_q;
  logic [PRICE_W-1:0]   mid_q;
  logic [BAND_W-1:0]    up_q;
  logic [BAND_W-1:0]    lo_q;
  logic                 out_vld_q;
  logic [PRICE_W-1:0]   out_mid_q;
  logic [BAND_W-1:0]    out_up_q;
  logic [BAND_W-1:0]    out_lo_q;

  logic                 accept;
  logic                 out_load;
  logic [LEN_W-1:0]     len_eff;
  logic [LEN_W:0]       old_sum;
  logic [SLOT_W-1:0]    old_slot;
  logic [SLOT_W-1:0]    next_slot;
  logic [PRICE_W-1:0]   ring_rdata;

  bbw_pkg::alu_ctrl_t   alu_ctrl;
  logic [ADD_W-1:0]     add_a;
  logic [ADD_W-1:0]     add_b;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [ADD_W-1:0]     add_res;
  logic                 borrow;
  logic [2*MUL_W-1:0]   prod;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // zero length counts as one, anything past the ring depth saturates
  always_comb begin
    if (wl_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(wl_q) > 32'(bbw_pkg::MAX_WINDOW)) begin
      len_eff = LEN_W'(bbw_pkg::MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(wl_q);
    end
  end

  always_comb begin
    old_sum = (LEN_W + 1)'(slot_q) + MaxWin - (LEN_W + 1)'(len_eff);
    if (old_sum >= MaxWin) begin
      old_sum = old_sum - MaxWin;
    end
    old_slot = old_sum[SLOT_W-1:0];
  end

  assign next_slot = ((LEN_W + 1)'(slot_q) == MaxWin - (LEN_W + 1)'(1)) ?
                     '0 : slot_q + SLOT_W'(1);

  bbw_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_q),
    .wdata_i (close_price_i),
    .re_i    (accept),
    .raddr_i (old_slot),
    .rdata_o (ring_rdata)
  );

  bbw_alu u_alu (
    .clk_i     (clk_i),
    .ctrl_i    (alu_ctrl),
    .add_a_i   (add_a),
    .add_b_i   (add_b),
    .mul_a_i   (mul_a),
    .mul_b_i   (mul_b),
    .add_res_o (add_res),
    .borrow_o  (borrow),
    .prod_o    (prod)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_ctrl = '0;
    add_a    = '0;
    add_b    = '0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_q)
      S_IDLE: begin
        mul_a           = MUL_W'(close_price_i);
        mul_b           = MUL_W'(close_price_i);
        alu_ctrl.mul_en = accept;
      end
      S_LOAD: begin
        add_a           = ADD_W'(sum_q);
        add_b           = ADD_W'(ring_rdata);
        alu_ctrl.sub    = 1'b1;
        mul_a           = MUL_W'(ring_rdata);
        mul_b           = MUL_W'(ring_rdata);
        alu_ctrl.mul_en = 1'b1;
      end
      S_UPD1: begin
        add_a        = ADD_W'(sq_q);
        add_b        = ADD_W'(prod);
        alu_ctrl.sub = 1'b1;
      end
      S_UPD2: begin
        add_a = ADD_W'(sum_q);
        add_b = ADD_W'(price_q);
      end
      S_UPD3: begin
        add_a = ADD_W'(sq_q);
        add_b = ADD_W'(nsq_q);
      end
      S_SQS: begin
        mul_a           = MUL_W'(sum_q);
        mul_b           = MUL_W'(sum_q);
        alu_ctrl.mul_en = 1'b1;
      end
      S_NLO: begin
        mul_a           = MUL_W'(len_eff);
        mul_b           = MUL_W'(sq_q[SUM_W-1:0]);
        alu_ctrl.mul_en = 1'b1;
      end
      S_NHI: begin
        mul_a           = MUL_W'(len_eff);
        mul_b           = MUL_W'(sq_q[SQ_W-1:SUM_W]);
        alu_ctrl.mul_en = 1'b1;
      end
      S_NCOMB: begin
        add_a = acc_q;
        add_b = ADD_W'(prod) << SUM_W;
      end
      S_NUM: begin
        add_a           = acc_q;
        add_b           = t_q;
        alu_ctrl.sub    = 1'b1;
        mul_a           = MUL_W'(len_eff);
        mul_b           = MUL_W'(len_eff);
        alu_ctrl.mul_en = 1'b1;
      end
      S_DIVM, S_DIVV: begin
        add_a        = ADD_W'({rem_q[REM_W-2:0], dvd_q[VAR_Q-1]});
        add_b        = ADD_W'(div_q);
        alu_ctrl.sub = 1'b1;
      end
      S_SQRT: begin
        // root and bit never overlap, so the or is their sum
        add_a        = ADD_W'(acc_q[VAR_Q-1:0]);
        add_b        = ADD_W'(root_q | bit_q);
        alu_ctrl.sub = 1'b1;
      end
      S_SCALE: begin
        mul_a           = MUL_W'(root_q);
        mul_b           = MUL_W'(bw_q);
        alu_ctrl.mul_en = 1'b1;
      end
      S_UP: begin
        add_a = ADD_W'(mid_q);
        add_b = ADD_W'(prod >> bbw_pkg::BW_FRAC);
      end
      S_LO: begin
        add_a        = ADD_W'(mid_q);
        add_b        = ADD_W'(prod >> bbw_pkg::BW_FRAC);
        alu_ctrl.sub = 1'b1;
      end
      default: begin
        alu_ctrl = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_LOAD;
      S_LOAD:  state_d = S_UPD1;
      S_UPD1:  state_d = S_UPD2;
      S_UPD2:  state_d = S_UPD3;
      S_UPD3:  state_d = vld_q ? S_SQS : S_OUT;
      S_SQS:   state_d = S_NLO;
      S_NLO:   state_d = S_NHI;
      S_NHI:   state_d = S_NCOMB;
      S_NCOMB: state_d = S_NUM;
      S_NUM:   state_d = S_DIVM;
      S_DIVM:  if (cnt_q == CNT_W'(1)) state_d = S_VSET;
      S_VSET:  state_d = S_DIVV;
      S_DIVV:  if (cnt_q == CNT_W'(1)) state_d = S_RSET;
      S_RSET:  state_d = S_SQRT;
      S_SQRT:  if (bit_q[0]) state_d = S_SCALE;
      S_SCALE: state_d = S_UP;
      S_UP:    state_d = S_LO;
      S_LO:    state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= bbw_pkg::WL_RESET;
      bw_q        <= bbw_pkg::BW_RESET;
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            slot_q <= next_slot;
            if (fill_q < len_eff) begin
              fill_q <= fill_q + LEN_W'(1);
            end
          end
        end
        S_LOAD: if (full_q) sum_q <= add_res[SUM_W-1:0];
        S_UPD1: if (full_q) sq_q <= add_res[SQ_W-1:0];
        S_UPD2: sum_q <= add_res[SUM_W-1:0];
        S_UPD3: sq_q <= add_res[SQ_W-1:0];
        default: begin
        end
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // must be written only while idle, so it never races the update above; the block does not enforce this
      if (cfg_we_i) begin
        if (cfg_index_i == bbw_pkg::CFG_WINDOW_LENGTH) begin
          wl_q   <= cfg_data_i[bbw_pkg::WL_W-1:0];
          slot_q <= '0;
          fill_q <= '0;
          sum_q  <= '0;
          sq_q   <= '0;
        end else if (cfg_index_i == bbw_pkg::CFG_BAND_WIDTH) begin
          bw_q <= cfg_data_i[bbw_pkg::BW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          price_q <= close_price_i;
          full_q  <= (fill_q >= len_eff);
          vld_q   <= ((LEN_W + 1)'(fill_q) + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(len_eff);
        end
      end
      S_LOAD:  nsq_q <= prod[2*PRICE_W-1:0];
      S_NLO:   t_q <= NUM_W'(prod);
      S_NHI:   acc_q <= NUM_W'(prod);
      S_NCOMB: acc_q <= add_res;
      S_NUM: begin
        acc_q <= add_res;
        // mean is below 2^PRICE_W, so the top bits start below the divisor
        rem_q <= REM_W'(sum_q[SUM_W-1:PRICE_W]);
        dvd_q <= {sum_q[PRICE_W-1:0], {(VAR_Q - PRICE_W){1'b0}}};
        div_q <= DSQ_W'(len_eff);
        cnt_q <= CNT_W'(PRICE_W);
      end
      S_DIVM, S_DIVV: begin
        dvd_q <= dvd_q << 1;
        quo_q <= {quo_q[VAR_Q-2:0], ~borrow};
        cnt_q <= cnt_q - CNT_W'(1);
        if (borrow) begin
          rem_q <= {rem_q[REM_W-2:0], dvd_q[VAR_Q-1]};
        end else begin
          rem_q <= add_res[REM_W-1:0];
        end
      end
      S_VSET: begin
        mid_q <= quo_q[PRICE_W-1:0];
        rem_q <= REM_W'(acc_q[NUM_W-1:VAR_Q]);
        dvd_q <= acc_q[VAR_Q-1:0];
        div_q <= prod[DSQ_W-1:0];
        cnt_q <= CNT_W'(VAR_Q);
      end
      S_RSET: begin
        acc_q  <= NUM_W'(quo_q);
        root_q <= '0;
        bit_q  <= RootBit0;
      end
      S_SQRT: begin
        bit_q <= bit_q >> 2;
        if (!borrow) begin
          acc_q  <= add_res;
          root_q <= (root_q >> 1) | bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      S_UP: up_q <= add_res[BAND_W-1:0];
      S_LO: lo_q <= add_res[BAND_W-1:0];
      S_OUT: begin
        if (out_load) begin
          out_vld_q <= vld_q;
          out_mid_q <= vld_q ? mid_q : '0;
          out_up_q  <= vld_q ? up_q : '0;
          out_lo_q  <= vld_q ? lo_q : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign bands_valid_o = out_vld_q;
  assign middle_band_o = out_mid_q;
  assign upper_band_o  = out_up_q;
  assign lower_band_o  = $signed(out_lo_q);

  // warm-up beats carry all-zero bands
  a_zero_bands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bands_valid_o |->
      middle_band_o == '0 && upper_band_o == '0 && lower_band_o == '0)
    else $error("warm-up result with nonzero bands");

  a_upper_ge_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bands_valid_o |-> upper_band_o >= BAND_W'(middle_band_o))
    else $error("upper band below middle band");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> fill_q <= len_eff)
    else $error("fill count past window length");

  // partial remainder of a restoring divide stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVM || state_q == S_DIVV) |-> rem_q < REM_W'(div_q))
    else $error("divider remainder not below divisor");

  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCALE |-> bit_q == '0)
    else $error("square root left before its last step");

endmodule

// File: src/bbw_ring.sv
// ----------------------------------------------------------------------------
// bbw_ring
// Price ring: one write port, one registered read port, read before write.
// ----------------------------------------------------------------------------
module bbw_ring (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [bbw_pkg::SLOT_W-1:0]  waddr_i,
  input  logic [bbw_pkg::PRICE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [bbw_pkg::SLOT_W-1:0]  raddr_i,
  output logic [bbw_pkg::PRICE_W-1:0] rdata_o
);

  logic [bbw_pkg::PRICE_W-1:0] mem_q [bbw_pkg::MAX_WINDOW];
  logic [bbw_pkg::PRICE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bbw_alu.sv
// ----------------------------------------------------------------------------
// bbw_alu
// Shared arithmetic unit: wide add/subtract with borrow, registered multiply.
// ----------------------------------------------------------------------------
module bbw_alu (
  input  logic                          clk_i,
  input  bbw_pkg::alu_ctrl_t            ctrl_i,
  input  logic [bbw_pkg::ADD_W-1:0]     add_a_i,
  input  logic [bbw_pkg::ADD_W-1:0]     add_b_i,
  input  logic [bbw_pkg::MUL_W-1:0]     mul_a_i,
  input  logic [bbw_pkg::MUL_W-1:0]     mul_b_i,
  output logic [bbw_pkg::ADD_W-1:0]     add_res_o,
  output logic                          borrow_o,
  output logic [2*bbw_pkg::MUL_W-1:0]   prod_o
);

  logic [bbw_pkg::ADD_W:0]       add_full;
  logic [2*bbw_pkg::MUL_W-1:0]   prod_q;

  always_comb begin
    if (ctrl_i.sub) begin
      add_full = {1'b0, add_a_i} - {1'b0, add_b_i};
    end else begin
      add_full = {1'b0, add_a_i} + {1'b0, add_b_i};
    end
  end

  assign add_res_o = add_full[bbw_pkg::ADD_W-1:0];
  // high bit is the borrow when subtracting
  assign borrow_o  = add_full[bbw_pkg::ADD_W];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mul_a_i * mul_b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: bench/bbw_band_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbw_band_checker
// Watches the config port and both beat channels, keeps its own copy of the
// price window and compares every band result with the predicted one.
// ----------------------------------------------------------------------------
module bbw_band_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [bbw_pkg::PRICE_W-1:0]    close_price_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           bands_valid_i,
  input  logic [bbw_pkg::PRICE_W-1:0]    middle_band_i,
  input  logic [bbw_pkg::BAND_W-1:0]     upper_band_i,
  input  logic [bbw_pkg::BAND_W-1:0]     lower_band_i,
  output int                             fail_count_o,
  output int                             outstanding_o,
  output int                             results_checked_o
);

  localparam int unsigned PRICE_W    = bbw_pkg::PRICE_W;
  localparam int unsigned BAND_W     = bbw_pkg::BAND_W;
  localparam int unsigned MAX_WINDOW = bbw_pkg::MAX_WINDOW;
  localparam int unsigned SLOT_W     = bbw_pkg::SLOT_W;
  localparam int unsigned WL_W       = bbw_pkg::WL_W;
  localparam int unsigned SUM_W      = bbw_pkg::SUM_W;
  localparam int unsigned SQ_W       = bbw_pkg::SQ_W;
  localparam int unsigned BW_W       = bbw_pkg::BW_W;
  localparam int unsigned BW_FRAC    = bbw_pkg::BW_FRAC;

  typedef struct packed {
    logic               bands_valid;
    logic [PRICE_W-1:0] middle;
    logic [BAND_W-1:0]  upper;
    logic [BAND_W-1:0]  lower;
  } band_set_t;

  logic [PRICE_W-1:0] price_window [MAX_WINDOW];
  logic [SLOT_W-1:0]  head_slot;
  logic [WL_W-1:0]    held_count;
  logic [SUM_W-1:0]   window_total;
  logic [SQ_W-1:0]    square_total;
  logic [WL_W-1:0]    win_len;
  logic [BW_W-1:0]    band_scale;

  band_set_t expected_bands [$];

  task automatic report_mismatch(input string what);
    fail_count_o++;
    $display("[%0t] band mismatch: %s", $time, what);
  endtask

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // pushes one price into the window and returns the bands it produces
  function automatic band_set_t slide_window(input logic [PRICE_W-1:0] price);
    int unsigned       len;
    logic [SLOT_W-1:0] oldest;
    logic [63:0]       n;
    logic [63:0]       mean;
    logic [63:0]       spread;
    logic [63:0]       dev;
    logic [63:0]       scaled;
    band_set_t         r;
    len = (win_len == 0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
    if (held_count >= len) begin
      // drop the price that falls out of the window, slot wraps mod ring depth
      oldest = head_slot - SLOT_W'(len);
      window_total = window_total - SUM_W'(price_window[oldest]);
      square_total = square_total -
                     SQ_W'(price_window[oldest]) * SQ_W'(price_window[oldest]);
    end else begin
      held_count++;
    end
    price_window[head_slot] = price;
    window_total = window_total + SUM_W'(price);
    square_total = square_total + SQ_W'(price) * SQ_W'(price);
    head_slot++;

    r = '0;
    if (held_count >= len) begin
      n      = len;
      mean   = window_total / n;
      spread = n * square_total - window_total * window_total;
      dev    = floor_root(spread / (n * n));
      scaled = (dev * band_scale) >> BW_FRAC;
      r.bands_valid = 1'b1;
      r.middle      = PRICE_W'(mean);
      r.upper       = BAND_W'(mean + scaled);
      r.lower       = BAND_W'(mean - scaled);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    band_set_t want;
    if (!rst_ni) begin
      win_len      = bbw_pkg::WL_RESET;
      band_scale   = bbw_pkg::BW_RESET;
      head_slot    = '0;
      held_count   = '0;
      window_total = '0;
      square_total = '0;
      expected_bands.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bbw_pkg::CFG_WINDOW_LENGTH: begin
            win_len      = cfg_data_i[WL_W-1:0];
            head_slot    = '0;
            held_count   = '0;
            window_total = '0;
            square_total = '0;
          end
          bbw_pkg::CFG_BAND_WIDTH: begin
            band_scale = cfg_data_i[BW_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_bands.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_bands.pop_front();
          results_checked_o++;
          if (bands_valid_i !== want.bands_valid)
            report_mismatch($sformatf("bands_valid got %0b want %0b",
                                      bands_valid_i, want.bands_valid));
          if (middle_band_i !== want.middle)
            report_mismatch($sformatf("middle_band got %0h want %0h",
                                      middle_band_i, want.middle));
          if (upper_band_i !== want.upper)
            report_mismatch($sformatf("upper_band got %0h want %0h",
                                      upper_band_i, want.upper));
          if (lower_band_i !== want.lower)
            report_mismatch($sformatf("lower_band got %0d want %0d",
                                      $signed(lower_band_i), $signed(want.lower)));
        end
      end

      if (in_valid_i && in_ready_i) begin
        expected_bands.insert(expected_bands.size(), slide_window(close_price_i));
      end

      outstanding_o <= expected_bands.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives price beats and register writes into the bollinger band window,
// with random gaps and output stalls; the checker does all the comparing.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned PRICE_W    = bbw_pkg::PRICE_W;
  localparam int unsigned BAND_W     = bbw_pkg::BAND_W;
  localparam int unsigned CFG_IDX_W  = bbw_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = bbw_pkg::CFG_DATA_W;
  localparam int unsigned WL_W       = bbw_pkg::WL_W;
  localparam int unsigned MAX_WINDOW = bbw_pkg::MAX_WINDOW;

  localparam int RANDOM_ITEMS  = 1450;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 150;

  // indexes past the register list, the block must ignore them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

  typedef enum int {
    MIX_NOISE,
    MIX_NEAR,
    MIX_EXTREME,
    MIX_FLAT
  } price_mix_e;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic [PRICE_W-1:0]    close_price = '0;
  logic                  out_ready   = 1'b0;

  wire                     in_ready;
  wire                     out_valid;
  wire                     bands_valid;
  wire [PRICE_W-1:0]       middle_band;
  wire [BAND_W-1:0]        upper_band;
  wire signed [BAND_W-1:0] lower_band;

  int fail_count;
  int outstanding;
  int results_checked;

  bit          steady         = 1'b0;
  int          beats_sent     = 0;
  int          directed_beats = 0;
  int          reg_writes     = 0;
  int          window_setups  = 0;
  int          cycle_count    = 0;
  int unsigned ready_hold     = 0;

  always #4 clk = ~clk;

  bollinger_band_window u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .close_price_i (close_price),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .bands_valid_o (bands_valid),
    .middle_band_o (middle_band),
    .upper_band_o  (upper_band),
    .lower_band_o  (lower_band)
  );

  bbw_band_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .close_price_i     (close_price),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .bands_valid_i     (bands_valid),
    .middle_band_i     (middle_band),
    .upper_band_i      (upper_band),
    .lower_band_i      (lower_band),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding),
    .results_checked_o (results_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: each result beat waits out a drawn stall before ready rises
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) ready_hold = steady ? 0 : $urandom_range(0, 11);
      if (ready_hold != 0) begin
        if (out_valid) ready_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_price(input logic [PRICE_W-1:0] price);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    close_price <= price;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // every beat yields a result, so an empty scoreboard means the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  function automatic logic [PRICE_W-1:0] next_price(input price_mix_e mix,
                                                    input logic [PRICE_W-1:0] base);
    case (mix)
      MIX_NOISE: return PRICE_W'($urandom);
      MIX_NEAR:  return base + PRICE_W'($urandom_range(0, 4095));
      MIX_EXTREME: begin
        if ($urandom_range(0, 2) == 0) return PRICE_W'($urandom);
        return ($urandom_range(0, 1) == 1) ? PRICE_MAX : '0;
      end
      default:   return ($urandom_range(0, 7) == 0) ? PRICE_W'($urandom) : base;
    endcase
  endfunction

  initial begin
    int unsigned        wl;
    int unsigned        eff_len;
    int unsigned        beat_count;
    int unsigned        pick;
    int                 random_beats;
    price_mix_e         mix;
    logic [PRICE_W-1:0] base;

    random_beats = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, window of 20 still filling
    steady = 1'b1;
    send_price(24'h000100);
    send_price(PRICE_MAX);
    send_price(24'h012345);
    drain();

    // short window, widest multiplier, widest swing
    steady = 1'b0;
    write_reg(bbw_pkg::CFG_WINDOW_LENGTH, CFG_DATA_W'(3));
    write_reg(bbw_pkg::CFG_BAND_WIDTH, '1);
    window_setups++;
    send_price('0);
    send_price(PRICE_MAX);
    send_price(PRICE_MAX);
    send_price('0);
    send_price(24'h555555);
    send_price(24'hAAAAAA);
    drain();

    // zero multiplier keeps the window, all three bands collapse
    write_reg(bbw_pkg::CFG_BAND_WIDTH, '0);
    send_price(PRICE_MAX);
    send_price('0);
    drain();

    // out-of-list indexes do nothing
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, CFG_DATA_W'(12'hABC));
    send_price(24'h7F00FF);
    drain();

    // length zero acts as one, upper data bits dropped
    write_reg(bbw_pkg::CFG_WINDOW_LENGTH, CFG_DATA_W'(12'hF80));
    write_reg(bbw_pkg::CFG_BAND_WIDTH, CFG_DATA_W'(256));
    window_setups++;
    send_price(24'h123456);
    send_price(PRICE_MAX);
    drain();

    write_reg(bbw_pkg::CFG_WINDOW_LENGTH, CFG_DATA_W'(2));
    write_reg(bbw_pkg::CFG_BAND_WIDTH, CFG_DATA_W'(2048));
    window_setups++;
    send_price(PRICE_MAX);
    send_price('0);
    send_price(24'h000001);
    send_price(24'hFFFFFE);
    drain();
    directed_beats = beats_sent;

    while (random_beats < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      wl = $urandom_range(1, 8);
      else if (pick < 70) wl = $urandom_range(9, 40);
      else if (pick < 80) wl = MAX_WINDOW;
      else if (pick < 88) wl = $urandom_range(41, 63);
      else if (pick < 95) wl = $urandom_range(65, 127);
      else                wl = 0;
      eff_len = (wl == 0) ? 1 : (wl > MAX_WINDOW) ? MAX_WINDOW : wl;

      write_reg(bbw_pkg::CFG_WINDOW_LENGTH,
                (CFG_DATA_W'($urandom_range(0, 31)) << WL_W) | CFG_DATA_W'(wl));
      pick = $urandom_range(0, 9);
      if (pick == 0)      write_reg(bbw_pkg::CFG_BAND_WIDTH, '0);
      else if (pick == 1) write_reg(bbw_pkg::CFG_BAND_WIDTH, '1);
      else if (pick < 7)  write_reg(bbw_pkg::CFG_BAND_WIDTH,
                                    CFG_DATA_W'($urandom_range(0, 4095)));
      window_setups++;

      beat_count = eff_len + $urandom_range(2, 30);
      mix        = price_mix_e'($urandom_range(0, 3));
      steady     = ($urandom_range(0, 3) == 0);
      base       = PRICE_W'($urandom_range(0, 24'hFFEFFF));

      for (int unsigned i = 0; i < beat_count; i++) begin
        if (i == beat_count / 2 && $urandom_range(0, 2) == 0) begin
          // mid-window register write, window must survive it
          drain();
          if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      CFG_DATA_W'($urandom));
          else
            write_reg(bbw_pkg::CFG_BAND_WIDTH, CFG_DATA_W'($urandom_range(0, 4095)));
        end
        send_price(next_price(mix, base));
        random_beats++;
      end
      drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d band results checked over %0d price beats, %0d of them directed",
             results_checked, beats_sent, directed_beats);
    $display("%0d register writes across %0d window setups, lengths 0 to 127",
             reg_writes, window_setups);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
